/* rtl/fpt_pkg.sv */
// Package for the fern posterior table: sizes, opcodes, transaction types,
// table entry layout and sequencer states. No dependencies.

package fpt_pkg;

  // Fern size and counter width.
  localparam int FEATURES   = 5;
  localparam int COUNT_BITS = 16;

  // Leaf addressing: two outcome bits per feature, capped at the input width.
  localparam int OUTCOME_BITS  = 2;
  localparam int CODE_BITS     = 10;
  localparam int LEAF_BITS_RAW = OUTCOME_BITS * FEATURES;
  localparam int LEAF_BITS     = (LEAF_BITS_RAW > CODE_BITS) ? CODE_BITS : LEAF_BITS_RAW;
  localparam logic [CODE_BITS-1:0] LEAF_MASK =
    CODE_BITS'((64'd1 << LEAF_BITS) - 64'd1);

  // The tables always span the full input code space.
  localparam int TABLE_DEPTH = 1 << CODE_BITS;

  // Q1.15 posterior; one quotient bit is produced per divider step.
  localparam int POST_BITS = 16;
  localparam int Q_STEPS   = POST_BITS;
  localparam int STEP_BITS = $clog2(Q_STEPS);
  localparam logic [POST_BITS-1:0] Q_ONE = POST_BITS'(32768);

  // Saturation value of a sample counter.
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Opcodes; the unused code behaves as classify.
  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_TRAIN    = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Input transaction.
  typedef struct packed {
    logic [1:0]           opcode;
    logic [CODE_BITS-1:0] feature_codes;
    logic                 is_positive;
  } item_t;

  // Result transaction.
  typedef struct packed {
    logic [CODE_BITS-1:0] leaf_index;
    logic [POST_BITS-1:0] posterior;
  } result_t;

  // One leaf of the fern as held in the table memory.
  typedef struct packed {
    logic [COUNT_BITS-1:0] pos;
    logic [COUNT_BITS-1:0] neg;
    logic [POST_BITS-1:0]  post;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

/* rtl/fpt_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.

module fpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fpt_divider.sv */
// Restoring divider for the leaf posterior floor(pos * 2^15 / total).
// One quotient bit per cycle. Depends on fpt_pkg.

module fpt_divider
  import fpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] pos,
  input  logic [COUNT_BITS:0]   total,
  output div_stat_t             stat,
  output logic [POST_BITS-1:0]  quotient
);

  localparam int REM_BITS = COUNT_BITS + 2;

  logic                  busy;
  logic                  done;
  logic [STEP_BITS-1:0]  step;
  logic [REM_BITS-1:0]   rem;
  logic [COUNT_BITS:0]   divisor;
  logic [POST_BITS-1:0]  quo;

  logic [REM_BITS-1:0]   shifted;
  logic                  fits;
  logic [REM_BITS-1:0]   rem_next;

  // One compare and subtract. The first step takes pos as it stands, since
  // pos may equal the divisor; later steps double the remainder.
  always_comb begin
    shifted  = (step == '0) ? rem : {rem[REM_BITS-2:0], 1'b0};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? (shifted - {1'b0, divisor}) : shifted;
  end

  // Control: busy until every quotient bit is produced, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_BITS'(1);
        if (step == STEP_BITS'(Q_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= {2'b00, pos};
      divisor <= total;
      quo     <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[POST_BITS-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

/* rtl/fern_posterior_table.sv */
// Top level of the fern posterior table: sequencer, leaf table memory and
// result register. Depends on fpt_pkg, fpt_ram and fpt_divider.

// One fern of a random-fern classifier. Each leaf holds a positive count, a
// negative count and a Q1.15 posterior in one memory word. Items are taken one
// at a time. A classify transaction goes through accept, memory read and
// result load. A train transaction goes through accept, memory read, then
// 16 steps of the shared restoring divider, one quotient bit each, its done
// cycle and the result load; when the updated count of positives is zero the
// divider is skipped, as in classify. After reset, and on every clear
// transaction, a clearing pass writes zero to all 1024 leaves, one per cycle,
// and no transaction is accepted meanwhile; the result of a clear is presented
// when the pass ends. A result waiting in the output register does not hold
// back the next accept, only the next result load.

module fern_posterior_table
  import fpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int ADDR_BITS = $clog2(TABLE_DEPTH);

  state_t state;
  state_t state_next;

  logic [1:0]           op_q;
  logic [CODE_BITS-1:0] leaf_q;
  logic                 label_q;
  logic                 emit;
  logic [ADDR_BITS-1:0] clr_addr;
  logic [COUNT_BITS-1:0] pos_q;
  logic [COUNT_BITS-1:0] neg_q;
  logic [POST_BITS-1:0] res_post;
  logic [POST_BITS-1:0] res_post_next;

  logic                 accept;
  logic                 load_out;
  logic                 keep_counts;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  entry_t               wb_entry;
  logic [ENTRY_BITS-1:0] ram_rdata;
  entry_t               rd;

  logic [COUNT_BITS-1:0] pos_new;
  logic [COUNT_BITS-1:0] neg_new;
  logic [COUNT_BITS:0]   total_new;

  logic                  div_start;
  div_stat_t             div_stat;
  logic [POST_BITS-1:0]  quotient;

  // Leaf table: counts and posterior side by side.
  fpt_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wb_entry),
    .raddr(ADDR_BITS'(item.feature_codes & LEAF_MASK)),
    .rdata(ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // Shared divider for the posterior update.
  fpt_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .pos     (pos_new),
    .total   (total_new),
    .stat    (div_stat),
    .quotient(quotient)
  );

  // Saturating counter update for a train transaction.
  always_comb begin
    pos_new = rd.pos;
    neg_new = rd.neg;
    if (label_q) begin
      if (rd.pos != COUNT_MAX) begin
        pos_new = rd.pos + COUNT_BITS'(1);
      end
    end else begin
      if (rd.neg != COUNT_MAX) begin
        neg_new = rd.neg + COUNT_BITS'(1);
      end
    end
    total_new = {1'b0, pos_new} + {1'b0, neg_new};
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next    = state;
    item_stall    = (state != S_IDLE);
    accept        = 1'b0;
    load_out      = 1'b0;
    keep_counts   = 1'b0;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ADDR_BITS'(leaf_q);
    wb_entry      = '0;
    res_post_next = res_post;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == ADDR_BITS'(TABLE_DEPTH - 1)) begin
          state_next = emit ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          accept = 1'b1;
          if (item.opcode == OP_CLEAR) begin
            res_post_next = '0;
            state_next    = S_CLEAR;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        res_post_next = rd.post;
        if (op_q == OP_TRAIN) begin
          keep_counts = 1'b1;
          if (pos_new != '0) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end else begin
            ram_we        = 1'b1;
            wb_entry.pos  = pos_new;
            wb_entry.neg  = neg_new;
            wb_entry.post = rd.post;
            state_next    = S_FINISH;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          ram_we        = 1'b1;
          wb_entry.pos  = pos_q;
          wb_entry.neg  = neg_q;
          wb_entry.post = quotient;
          res_post_next = quotient;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers: clearing pass address and the clear-result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      emit     <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_BITS'(1);
      end
      if (accept) begin
        emit     <= (item.opcode == OP_CLEAR);
        clr_addr <= '0;
      end
    end
  end

  // Transaction registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= item.opcode;
      label_q <= item.is_positive;
      if (item.opcode == OP_CLEAR) begin
        leaf_q <= '0;
      end else begin
        leaf_q <= item.feature_codes & LEAF_MASK;
      end
    end
    if (keep_counts) begin
      pos_q <= pos_new;
      neg_q <= neg_new;
    end
    res_post <= res_post_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.leaf_index <= leaf_q;
      result.posterior  <= res_post;
    end
  end

  // Checks on the sequencer and divider working together.
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divider idle while the sequencer waits on it");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (quotient <= Q_ONE))
    else $error("posterior above one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !load_out)
    else $error("pending result overwritten");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !ram_we)
    else $error("table written while a transaction is accepted");

endmodule
